// ----- rtl/core/assert_macros.svh -----
// assertion macros used by the queue rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, masked while reset is held
`define SPQ_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("queue assertion failed");

// clocked check that also runs during reset
`define SPQ_ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("queue assertion failed");

`endif

// ----- rtl/core/spq_pkg.sv -----
// types and constants of the sorted priority queue
`default_nettype none

package spq_pkg;

  localparam int unsigned VALUE_W = 32;
  localparam int unsigned PRI_W   = 8;
  localparam int unsigned CNT_W   = 5;

  localparam logic MODE_INSERT = 1'b0;
  localparam logic MODE_REMOVE = 1'b1;

  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    logic        [PRI_W-1:0]   pri;
  } entry_t;

  // per-step command broadcast to every cell
  typedef struct packed {
    logic   ins;
    logic   rem;
    entry_t ent;
  } ctrl_t;

endpackage

`default_nettype wire

// ----- rtl/core/spq_cell.sv -----
// one slot of the sorted chain
`default_nettype none

module spq_cell #(
  parameter int unsigned IDX = 0
) (
  input  wire logic           clk,
  input  wire spq_pkg::ctrl_t ctrl,
  input  wire logic           occ,
  input  wire spq_pkg::entry_t left_ent,
  input  wire logic           left_keep,
  input  wire spq_pkg::entry_t right_ent,
  output spq_pkg::entry_t     ent,
  output logic                keep
);
  import spq_pkg::*;

  entry_t ent_r;
  entry_t ent_nxt;

  // slot 0 stays unless its priority is strictly greater, later slots on strict less
  always_comb begin
    if (IDX == 0) begin
      keep = occ && (ent_r.pri <= ctrl.ent.pri);
    end else begin
      keep = occ && (ent_r.pri < ctrl.ent.pri);
    end
  end

  always_comb begin
    ent_nxt = ent_r;
    if (ctrl.ins && !keep) begin
      ent_nxt = left_keep ? ctrl.ent : left_ent;
    end else if (ctrl.rem) begin
      ent_nxt = right_ent;
    end
  end

  always_ff @(posedge clk) begin
    ent_r <= ent_nxt;
  end

  assign ent = ent_r;

endmodule

`default_nettype wire

// ----- rtl/core/sorted_priority_queue.sv -----
// sorted priority queue top level: chain of slots plus count and result register
// the result of an item is registered and valid the cycle after the item is accepted
// throughput: one item per cycle; the next item is taken in the same cycle the result is taken
// every slot compares its priority with the new one in parallel and shifts by one place
// reset clears the entry count and the result valid and accepted flags; slot contents stay undefined
// slots at or beyond the count are never shown, so no clearing pass is needed
`default_nettype none
`include "assert_macros.svh"

module sorted_priority_queue #(
  parameter int unsigned CAPACITY = 16
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  // item input
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic                           in_mode,
  input  wire logic signed [spq_pkg::VALUE_W-1:0] in_value,
  input  wire logic        [spq_pkg::PRI_W-1:0]   in_priority_req,
  // result output
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic                                out_accepted,
  output logic signed [spq_pkg::VALUE_W-1:0]  out_head_value,
  output logic        [spq_pkg::PRI_W-1:0]    out_head_priority,
  output logic                                out_not_empty,
  output logic        [spq_pkg::CNT_W-1:0]    out_count
);
  import spq_pkg::*;

  // count runs from 0 to CAPACITY inclusive
  localparam int unsigned CW = $clog2(CAPACITY + 1);

  logic          in_fire;
  ctrl_t         ctrl;
  logic [CW-1:0] count_r;
  logic [CW-1:0] count_nxt;
  logic          out_valid_r;
  logic          out_accepted_r;

  entry_t        ent  [CAPACITY];
  logic          keep [CAPACITY];
  logic          occ  [CAPACITY];

  // a new item enters whenever the result slot is free or being drained
  assign in_ready = !out_valid_r || out_ready;
  assign in_fire  = in_valid && in_ready;

  // full insert and empty remove become no-ops
  always_comb begin
    ctrl.ent.value = in_value;
    ctrl.ent.pri   = in_priority_req;
    ctrl.ins = in_fire && (in_mode == MODE_INSERT) && (count_r < CW'(CAPACITY));
    ctrl.rem = in_fire && (in_mode == MODE_REMOVE) && (count_r != '0);
  end

  always_comb begin
    count_nxt = count_r;
    if (ctrl.ins) begin
      count_nxt = count_r + 1'b1;
    end else if (ctrl.rem) begin
      count_nxt = count_r - 1'b1;
    end
  end

  // chain of slots, slot 0 holds the head
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    assign occ[i] = CW'(i) < count_r;

    if (i == 0) begin : g_first
      // boundary: a displaced head slot always takes the new item
      spq_cell #(.IDX(i)) u_cell (
        .clk       (clk),
        .ctrl      (ctrl),
        .occ       (occ[i]),
        .left_ent  (ctrl.ent),
        .left_keep (1'b1),
        .right_ent (ent[(i + 1) % CAPACITY]),
        .ent       (ent[i]),
        .keep      (keep[i])
      );
    end else if (i == CAPACITY - 1) begin : g_last
      // the tail has no right neighbor; what it loads on a remove is past the count
      spq_cell #(.IDX(i)) u_cell (
        .clk       (clk),
        .ctrl      (ctrl),
        .occ       (occ[i]),
        .left_ent  (ent[i - 1]),
        .left_keep (keep[i - 1]),
        .right_ent (ent[i]),
        .ent       (ent[i]),
        .keep      (keep[i])
      );
    end else begin : g_mid
      spq_cell #(.IDX(i)) u_cell (
        .clk       (clk),
        .ctrl      (ctrl),
        .occ       (occ[i]),
        .left_ent  (ent[i - 1]),
        .left_keep (keep[i - 1]),
        .right_ent (ent[i + 1]),
        .ent       (ent[i]),
        .keep      (keep[i])
      );
    end
  end

  // count and result flags; head fields are read straight from slot 0
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r        <= '0;
      out_valid_r    <= 1'b0;
      out_accepted_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      if (in_fire) begin
        out_valid_r    <= 1'b1;
        out_accepted_r <= ctrl.ins || ctrl.rem;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // while a result waits, no item enters, so count and slot 0 hold still
  assign out_valid         = out_valid_r;
  assign out_accepted      = out_accepted_r;
  assign out_not_empty     = count_r != '0;
  assign out_head_value    = out_not_empty ? ent[0].value : '0;
  assign out_head_priority = out_not_empty ? ent[0].pri : '0;
  assign out_count         = CNT_W'(count_r);

  // count never runs past the capacity
  `SPQ_ASSERT(a_count_bound, count_r <= CW'(CAPACITY))
  // an insert that takes effect grows the count by one
  `SPQ_ASSERT(a_ins_grow, ctrl.ins |=> count_r == $past(count_r) + 1'b1)
  // a remove that takes effect shrinks the count by one
  `SPQ_ASSERT(a_rem_shrink, ctrl.rem |=> count_r == $past(count_r) - 1'b1)
  // a waiting result keeps the entry count stable
  `SPQ_ASSERT(a_hold_state, out_valid_r && !out_ready |=> $stable(count_r))

endmodule

`default_nettype wire
